// ----- hdl/lffn_pkg.sv -----
// Shared types and constants for the log flat-field normalizer.
// No dependencies; used by all lffn_* modules and the top level.
package lffn_pkg;

  typedef enum logic {
    OP_PREPARE   = 1'b0,
    OP_NORMALIZE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [15:0]        pixel_value;
    logic [15:0]        dark_value;
    logic signed [23:0] reference_value;
    logic [31:0]        dose;
    logic               slice_end;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] result_value;
    logic               dose_zero;
    logic               slice_end_out;
  } out_word_t;

  localparam int unsigned LOG_STEPS = 24;             // fraction bits of log2
  localparam int unsigned LOG_LAT   = LOG_STEPS + 3;  // normalize + steps + mult + round
  localparam logic [31:0] LN2_Q32   = 32'hB17217F8;
  localparam int unsigned SUM_W     = 26;             // ref +/- two log terms
  localparam int unsigned OUT_W     = 24;

  // One step of the squaring log2: mantissa Q1.31, exponent, fraction so far
  typedef struct packed {
    logic [31:0]          m;
    logic [4:0]           e;
    logic [LOG_STEPS-1:0] f;
  } log_state_t;

  // Per-word control that travels alongside the log pipeline
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic signed [23:0] ref_val;
    logic               dose_term;
    logic               dose_zero;
    logic               diff_pos;
    logic               slice_end;
  } side_t;

endpackage

// ----- hdl/lffn_log_stage.sv -----
// One squaring step of the fixed-point log2: square, test overflow, halve.
// Depends on lffn_pkg (log_state_t).
module lffn_log_stage (
  input  logic                clk,
  input  logic                en,
  input  lffn_pkg::log_state_t d,
  output lffn_pkg::log_state_t q_r
);

  logic [63:0]          sq;
  logic [32:0]          t;
  lffn_pkg::log_state_t q_nxt;

  assign sq = d.m * d.m;
  assign t  = sq[63:31];

  always_comb begin
    q_nxt   = d;
    q_nxt.f = {d.f[lffn_pkg::LOG_STEPS-2:0], t[32]};
    // m*m >= 2.0 emits a one and renormalizes
    q_nxt.m = t[32] ? t[32:1] : t[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ----- hdl/lffn_log.sv -----
// Pipelined natural log in fixed point: normalize, squaring steps, ln2 scale, round.
// Depends on lffn_pkg and lffn_log_stage.
module lffn_log #(
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned LN_W      = FRAC_BITS + 5
) (
  input  logic            clk,
  input  logic            en,
  input  logic [31:0]     x,
  output logic [LN_W-1:0] ln_r
);

  localparam int unsigned LG_W   = 5 + lffn_pkg::LOG_STEPS;
  localparam int unsigned PROD_W = LG_W + 32;
  localparam int unsigned SHIFT  = lffn_pkg::LOG_STEPS + 32 - FRAC_BITS;

  lffn_pkg::log_state_t st [lffn_pkg::LOG_STEPS+1];
  lffn_pkg::log_state_t norm_nxt;
  logic [4:0]           msb;
  logic [LG_W-1:0]      lg;
  logic [PROD_W-1:0]    prod_nxt;
  logic [PROD_W-1:0]    prod_r;
  logic [PROD_W-1:0]    rnd;

  // leading one position; x is nonzero wherever the result is used
  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        msb = 5'(i);
      end
    end
  end

  always_comb begin
    norm_nxt.m = x << (5'd31 - msb);
    norm_nxt.e = msb;
    norm_nxt.f = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= norm_nxt;
    end
  end

  for (genvar g = 0; g < lffn_pkg::LOG_STEPS; g++) begin : g_step
    lffn_log_stage u_stage (
      .clk (clk),
      .en  (en),
      .d   (st[g]),
      .q_r (st[g+1])
    );
  end

  assign lg       = {st[lffn_pkg::LOG_STEPS].e, st[lffn_pkg::LOG_STEPS].f};
  assign prod_nxt = lg * lffn_pkg::LN2_Q32;
  // round half up to FRAC_BITS fraction bits
  assign rnd      = prod_r + (PROD_W'(1) << (SHIFT - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      ln_r   <= rnd[SHIFT +: LN_W];
    end
  end

endmodule

// ----- hdl/log_flat_field_normalize.sv -----
// Log flat-field normalizer top level. Path from input word to
// output word: input register, log pipeline (normalize, 24 squaring
// multipliers, ln2 multiply, round) and the combine/saturate output register.
// Throughput one word per clock; a stalled output word freezes the whole pipe.
// Synchronous reset clears all valid bits and use_dose. Depends on lffn_pkg, lffn_log.
module log_flat_field_normalize #(
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lffn_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lffn_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int unsigned LN_W = FRAC_BITS + 5;
  localparam logic [15:0] PIX_MASK = (PIXEL_BITS >= 16) ? 16'hFFFF
                                     : 16'((32'd1 << PIXEL_BITS) - 32'd1);
  localparam logic signed [lffn_pkg::SUM_W-1:0] SAT_MAX =
    lffn_pkg::SUM_W'((32'sd1 <<< (lffn_pkg::OUT_W - 1)) - 32'sd1);
  localparam logic signed [lffn_pkg::SUM_W-1:0] SAT_MIN =
    lffn_pkg::SUM_W'(-(32'sd1 <<< (lffn_pkg::OUT_W - 1)));

  logic                en;
  logic                use_dose_r;
  logic [16:0]         diff;
  lffn_pkg::side_t     in_side_nxt;
  lffn_pkg::side_t     in_side_r;
  logic [31:0]         dose_x_r;
  logic [31:0]         diff_x_r;
  lffn_pkg::side_t     side_r [lffn_pkg::LOG_LAT];
  lffn_pkg::side_t     last;
  logic [LN_W-1:0]     ln_dose;
  logic [LN_W-1:0]     ln_diff;
  logic signed [lffn_pkg::SUM_W-1:0] dterm;
  logic signed [lffn_pkg::SUM_W-1:0] lterm;
  logic signed [lffn_pkg::SUM_W-1:0] refx;
  logic signed [lffn_pkg::SUM_W-1:0] sum;
  lffn_pkg::out_word_t out_nxt;
  lffn_pkg::out_word_t out_data_r;
  logic                out_valid_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_dose_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      use_dose_r <= cfg_data;
    end
  end

  // input stage: pixel difference and dose-term decisions
  assign diff = {1'b0, in_data.pixel_value & PIX_MASK}
              - {1'b0, in_data.dark_value & PIX_MASK};

  always_comb begin
    logic used;
    used = (in_data.operation == lffn_pkg::OP_PREPARE) || use_dose_r;
    in_side_nxt.valid     = in_valid;
    in_side_nxt.op        = in_data.operation;
    in_side_nxt.ref_val   = in_data.reference_value;
    in_side_nxt.dose_term = used && (in_data.dose != '0);
    in_side_nxt.dose_zero = used && (in_data.dose == '0);
    in_side_nxt.diff_pos  = !diff[16] && (diff[15:0] != '0);
    in_side_nxt.slice_end = in_data.slice_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_side_r.valid <= 1'b0;
    end else if (en) begin
      in_side_r <= in_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dose_x_r <= in_data.dose;
      diff_x_r <= {16'h0000, diff[15:0]};
    end
  end

  lffn_log #(.FRAC_BITS(FRAC_BITS), .LN_W(LN_W)) u_log_dose (
    .clk  (clk),
    .en   (en),
    .x    (dose_x_r),
    .ln_r (ln_dose)
  );

  lffn_log #(.FRAC_BITS(FRAC_BITS), .LN_W(LN_W)) u_log_diff (
    .clk  (clk),
    .en   (en),
    .x    (diff_x_r),
    .ln_r (ln_diff)
  );

  // control line matched to the log latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lffn_pkg::LOG_LAT; i++) begin
        side_r[i].valid <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= in_side_r;
      for (int i = 1; i < lffn_pkg::LOG_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign last  = side_r[lffn_pkg::LOG_LAT-1];
  assign dterm = last.dose_term
               ? $signed({{(lffn_pkg::SUM_W-LN_W){1'b0}}, ln_dose}) : '0;
  assign lterm = last.diff_pos
               ? $signed({{(lffn_pkg::SUM_W-LN_W){1'b0}}, ln_diff}) : '0;
  assign refx  = {{(lffn_pkg::SUM_W-lffn_pkg::OUT_W){last.ref_val[23]}}, last.ref_val};

  always_comb begin
    unique case (last.op)
      lffn_pkg::OP_PREPARE:   sum = lterm - dterm;
      lffn_pkg::OP_NORMALIZE: sum = last.diff_pos ? (refx - lterm + dterm) : refx;
      default:                sum = refx;
    endcase
    priority if (sum > SAT_MAX) begin
      out_nxt.result_value = SAT_MAX[lffn_pkg::OUT_W-1:0];
    end else if (sum < SAT_MIN) begin
      out_nxt.result_value = SAT_MIN[lffn_pkg::OUT_W-1:0];
    end else begin
      out_nxt.result_value = sum[lffn_pkg::OUT_W-1:0];
    end
    out_nxt.dose_zero     = last.dose_zero;
    out_nxt.slice_end_out = last.slice_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench for log_flat_field_normalize: directed table, then random pixel words.
// Three idle mixes and one long output hold. Needs lffn_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int PIPE_LAT    = 29;
  localparam int FRAC        = 12;
  localparam int LOG2_FRAC   = 24;
  localparam logic [63:0] LN2_FIX = 64'h0000_0000_B172_17F8;
  localparam longint SAT_MAX = 8388607;
  localparam longint SAT_MIN = -8388608;
  localparam int RAND_WORDS  = 510;   // per idle mix
  localparam int HOLD_CYCLES = 400;
  localparam int DIR_ROWS    = 17;

  typedef struct {
    lffn_pkg::in_word_t  word;
    bit                  dose_on;
    bit                  typed;
    lffn_pkg::out_word_t want;
  } dir_row_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  lffn_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lffn_pkg::out_word_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  lffn_pkg::out_word_t expected_q[$];
  lffn_pkg::out_word_t head;
  dir_row_t  dir_tab[DIR_ROWS];
  bit        use_dose_cfg;
  int        in_idle_pct;
  int        out_idle_pct;
  int        fail_count = 0;
  int        held_cycles = 0;
  int        prep_count;
  int        norm_count;
  int        zero_dose_count;
  int        hold_req = 0;
  int        hold_ack = 0;
  int        hold_left = 0;

  log_flat_field_normalize dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ln(x) in Q.12 by repeated squaring of the Q1.31 mantissa, x >= 1
  function automatic longint ln_q12(input logic [31:0] x);
    int          e;
    int          i;
    logic [63:0] m;
    logic [63:0] f;
    logic [63:0] prod;
    e = 31;
    while (e > 0 && !x[e]) e--;
    m = ({32'd0, x} << (31 - e)) & 64'hFFFF_FFFF;
    f = '0;
    for (i = 0; i < LOG2_FRAC; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= 64'h1_0000_0000) begin
        f = f | 64'd1;
        m = m >> 1;
      end
    end
    prod = ((64'(e) << LOG2_FRAC) | f) * LN2_FIX;
    prod = prod + (64'd1 << (LOG2_FRAC + 32 - FRAC - 1));
    return longint'(prod >> (LOG2_FRAC + 32 - FRAC));
  endfunction

  function automatic lffn_pkg::out_word_t predict_pixel(input lffn_pkg::in_word_t w,
                                                        input bit add_dose);
    longint              diff;
    longint              dterm;
    longint              refv;
    longint              res;
    bit                  dz;
    lffn_pkg::out_word_t r;
    diff  = longint'(w.pixel_value) - longint'(w.dark_value);
    refv  = longint'($signed(w.reference_value));
    dterm = 0;
    dz    = 1'b0;
    // dose is only looked at when its log term is part of the sum
    if (w.operation == lffn_pkg::OP_PREPARE || add_dose) begin
      if (w.dose == 32'd0) dz = 1'b1;
      else dterm = ln_q12(w.dose);
    end
    if (w.operation == lffn_pkg::OP_PREPARE) begin
      res = (diff > 0) ? ln_q12(diff[31:0]) - dterm : -dterm;
    end else begin
      res = (diff > 0) ? refv - ln_q12(diff[31:0]) + dterm : refv;
    end
    if (res > SAT_MAX) res = SAT_MAX;
    if (res < SAT_MIN) res = SAT_MIN;
    r.result_value  = res[23:0];
    r.dose_zero     = dz;
    r.slice_end_out = w.slice_end;
    return r;
  endfunction

  function automatic lffn_pkg::in_word_t pix_word(input lffn_pkg::op_t op,
                                                  input logic [15:0] p,
                                                  input logic [15:0] d,
                                                  input logic [23:0] rv,
                                                  input logic [31:0] ds, input logic se);
    lffn_pkg::in_word_t w;
    w.operation       = op;
    w.pixel_value     = p;
    w.dark_value      = d;
    w.reference_value = rv;
    w.dose            = ds;
    w.slice_end       = se;
    return w;
  endfunction

  function automatic lffn_pkg::out_word_t res_word(input logic [23:0] v, input logic dz,
                                                   input logic se);
    lffn_pkg::out_word_t r;
    r.result_value  = v;
    r.dose_zero     = dz;
    r.slice_end_out = se;
    return r;
  endfunction

  function automatic lffn_pkg::in_word_t random_pixel();
    lffn_pkg::in_word_t w;
    w.operation = $urandom_range(1) ? lffn_pkg::OP_NORMALIZE : lffn_pkg::OP_PREPARE;
    w.pixel_value = 16'($urandom);
    w.dark_value  = 16'($urandom);
    case ($urandom_range(5))
      0: w.dark_value = w.pixel_value - 16'($urandom_range(6)) + 16'd3;  // diff near zero
      1: begin
        w.pixel_value = 16'($urandom_range(64));
        w.dark_value  = 16'($urandom_range(16));
      end
      2: w.dark_value = '0;
      default: ;
    endcase
    case ($urandom_range(7))
      0: w.dose = '0;
      1: w.dose = 32'd1 << $urandom_range(31);
      2: w.dose = $urandom_range(1, 255);
      3: w.dose = 32'hFFFF_FFFF;
      default: w.dose = $urandom;
    endcase
    case ($urandom_range(7))
      0: w.reference_value = 24'h7FFFFF;
      1: w.reference_value = 24'h800000;
      2: w.reference_value = 24'($signed($urandom_range(8192))) - 24'sd4096;
      default: w.reference_value = 24'($urandom);
    endcase
    w.slice_end = ($urandom_range(15) == 0);
    return w;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Offer one word, holding it until accepted; expectation is queued on accept
  task automatic send_word(input lffn_pkg::in_word_t w, input bit typed,
                           input lffn_pkg::out_word_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(typed ? want : predict_pixel(w, use_dose_cfg));
    if (w.operation == lffn_pkg::OP_PREPARE) prep_count++;
    else norm_count++;
    if (w.dose == 32'd0) zero_dose_count++;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic set_use_dose(input bit v);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    use_dose_cfg = v;
  endtask

  // Result side: random stall, plus a long hold on request
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) held_cycles++;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          log_failure($sformatf("%0t: result word %h with nothing expected", $time, out_data));
        end else begin
          head = expected_q.pop_front();
          if (out_data.result_value !== head.result_value ||
              out_data.dose_zero !== head.dose_zero ||
              out_data.slice_end_out !== head.slice_end_out) begin
            log_failure($sformatf("%0t: got value %h dz %b se %b, want %h dz %b se %b",
                                  $time, out_data.result_value, out_data.dose_zero,
                                  out_data.slice_end_out, head.result_value,
                                  head.dose_zero, head.slice_end_out));
          end
        end
      end
    end
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int ph;
    int k;
    prep_count = 0;
    norm_count = 0;
    zero_dose_count = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    use_dose_cfg = 1'b0;

    // extremes, pass-through and saturation cases typed in; the rest predicted
    dir_tab[0]  = '{pix_word(lffn_pkg::OP_PREPARE, 16'h0, 16'h0, 24'h0, 32'h0, 1'b0),
                    1'b0, 1'b1, res_word(24'h0, 1'b1, 1'b0)};
    dir_tab[1]  = '{pix_word(lffn_pkg::OP_PREPARE, 16'h1, 16'h0, 24'h0, 32'h1, 1'b0),
                    1'b0, 1'b1, res_word(24'h0, 1'b0, 1'b0)};
    dir_tab[2]  = '{pix_word(lffn_pkg::OP_PREPARE, 16'hFFFF, 16'h0, 24'h0, 32'h1, 1'b0),
                    1'b0, 1'b0, '0};
    dir_tab[3]  = '{pix_word(lffn_pkg::OP_PREPARE, 16'h0, 16'hFFFF, 24'h0, 32'hFFFF_FFFF,
                             1'b0), 1'b0, 1'b0, '0};
    dir_tab[4]  = '{pix_word(lffn_pkg::OP_PREPARE, 16'hFFFF, 16'h0, 24'h0, 32'h0, 1'b0),
                    1'b0, 1'b0, '0};
    dir_tab[5]  = '{pix_word(lffn_pkg::OP_PREPARE, 16'h100, 16'h1, 24'h7FFFFF, 32'h1000,
                             1'b0), 1'b0, 1'b0, '0};
    dir_tab[6]  = '{pix_word(lffn_pkg::OP_NORMALIZE, 16'h0, 16'hFFFF, 24'h7FFFFF, 32'h0,
                             1'b0), 1'b0, 1'b1, res_word(24'h7FFFFF, 1'b0, 1'b0)};
    dir_tab[7]  = '{pix_word(lffn_pkg::OP_NORMALIZE, 16'h5, 16'h5, 24'h800000,
                             32'hFFFF_FFFF, 1'b1), 1'b0, 1'b1,
                    res_word(24'h800000, 1'b0, 1'b1)};
    dir_tab[8]  = '{pix_word(lffn_pkg::OP_NORMALIZE, 16'hFFFF, 16'h0, 24'h800000, 32'h0,
                             1'b0), 1'b0, 1'b1, res_word(24'h800000, 1'b0, 1'b0)};
    dir_tab[9]  = '{pix_word(lffn_pkg::OP_NORMALIZE, 16'h2, 16'h1, 24'h0, 32'h0, 1'b0),
                    1'b0, 1'b1, res_word(24'h0, 1'b0, 1'b0)};
    dir_tab[10] = '{pix_word(lffn_pkg::OP_NORMALIZE, 16'h1000, 16'h0, 24'h012345, 32'd77,
                             1'b1), 1'b0, 1'b0, '0};
    dir_tab[11] = '{pix_word(lffn_pkg::OP_NORMALIZE, 16'hFFFF, 16'h0, 24'h7FFFFF,
                             32'hFFFF_FFFF, 1'b0), 1'b1, 1'b1,
                    res_word(24'h7FFFFF, 1'b0, 1'b0)};
    dir_tab[12] = '{pix_word(lffn_pkg::OP_NORMALIZE, 16'h10, 16'h3, 24'h0, 32'h0, 1'b0),
                    1'b1, 1'b0, '0};
    dir_tab[13] = '{pix_word(lffn_pkg::OP_NORMALIZE, 16'h3, 16'h10, 24'h0, 32'h0, 1'b0),
                    1'b1, 1'b1, res_word(24'h0, 1'b1, 1'b0)};
    dir_tab[14] = '{pix_word(lffn_pkg::OP_NORMALIZE, 16'h3, 16'h10, 24'hFFFFFF, 32'h5,
                             1'b0), 1'b1, 1'b1, res_word(24'hFFFFFF, 1'b0, 1'b0)};
    dir_tab[15] = '{pix_word(lffn_pkg::OP_PREPARE, 16'h8000, 16'h7FFF, 24'h0,
                             32'h8000_0000, 1'b0), 1'b1, 1'b0, '0};
    dir_tab[16] = '{pix_word(lffn_pkg::OP_PREPARE, 16'h0, 16'h0, 24'h0, 32'h1, 1'b1),
                    1'b1, 1'b1, res_word(24'h0, 1'b0, 1'b1)};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_use_dose(1'b0);
    for (k = 0; k < DIR_ROWS; k++) begin
      if (dir_tab[k].dose_on != use_dose_cfg) set_use_dose(dir_tab[k].dose_on);
      send_word(dir_tab[k].word, dir_tab[k].typed, dir_tab[k].want);
    end

    // receiver-heavy idling, then sender-heavy, then back to back
    for (ph = 0; ph < 3; ph++) begin
      set_use_dose(ph != 0);
      in_idle_pct  = (ph == 0) ? 25 : (ph == 1) ? 47 : 0;
      out_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 25 : 0;
      for (k = 0; k < RAND_WORDS; k++) begin
        if (ph == 2 && k == 100) hold_req <= hold_req + 1;
        send_word(random_pixel(), 1'b0, '0);
      end
    end

    drain_pipe();
    $display("Covered %0d prepare and %0d normalize words, %0d with zero dose, use_dose 0 and 1",
             prep_count, norm_count, zero_dose_count);
    $display("Input side held back for %0d cycles; %0d mismatches", held_cycles, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lffn_pkg.sv
hdl/lffn_log_stage.sv
hdl/lffn_log.sv
hdl/log_flat_field_normalize.sv
dv/tb_top.sv
